// File: hw/rtl/shcfr_pkg.sv
// ----------------------------------------------------------------------------
// shcfr_pkg
// Shared types and constants of the sync/header/CRC-32 frame receiver.
// ----------------------------------------------------------------------------
package shcfr_pkg;

  localparam int unsigned HdrLen = 6;
  localparam int unsigned CrcLen = 4;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [1:0] RegSyncFirst  = 2'd0;
  localparam logic [1:0] RegSyncSecond = 2'd1;
  localparam logic [1:0] RegVersion    = 2'd2;
  localparam logic [1:0] RegMaxPayload = 2'd3;

  localparam logic [7:0]  SyncFirstRst  = 8'h55;
  localparam logic [7:0]  SyncSecondRst = 8'hAA;
  localparam logic [7:0]  VersionRst    = 8'h01;
  localparam logic [15:0] MaxPayloadRst = 16'd1028;

  // result kinds
  localparam logic ResPayload = 1'b0;
  localparam logic ResVerdict = 1'b1;

  // verdict status codes
  localparam logic [1:0] StOk         = 2'd0;
  localparam logic [1:0] StBadVersion = 2'd1;
  localparam logic [1:0] StBadLength  = 2'd2;
  localparam logic [1:0] StBadCrc     = 2'd3;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  expected_version;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic        result_type;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [7:0]  command;
    logic [15:0] sequence_res;
    logic [15:0] frame_length;
    logic [31:0] computed_crc;
  } res_t;

endpackage

// File: hw/rtl/shcfr_rx_if.sv
// ----------------------------------------------------------------------------
// shcfr_rx_if
// Received-byte channel: valid/ready handshake with one byte per word.
// ----------------------------------------------------------------------------
interface shcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/shcfr_res_if.sv
// ----------------------------------------------------------------------------
// shcfr_res_if
// Result channel: payload bytes and end-of-frame verdicts.
// ----------------------------------------------------------------------------
interface shcfr_res_if;
  logic        valid;
  logic        ready;
  logic        result_type;
  logic [7:0]  data_byte;
  logic [1:0]  status;
  logic [7:0]  command;
  logic [15:0] sequence_res;
  logic [15:0] frame_length;
  logic [31:0] computed_crc;

  modport source (output valid, output result_type, output data_byte, output status,
                  output command, output sequence_res, output frame_length,
                  output computed_crc, input ready);
  modport sink   (input valid, input result_type, input data_byte, input status,
                  input command, input sequence_res, input frame_length,
                  input computed_crc, output ready);
endinterface

// File: hw/rtl/shcfr_crc8.sv
// ----------------------------------------------------------------------------
// shcfr_crc8
// Byte-wide update of a reflected CRC-32 register (unrolled over 8 bits).
// ----------------------------------------------------------------------------
module shcfr_crc8
  import shcfr_pkg::*;
(
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  logic [31:0] c;

  always_comb begin
    c = crc_i ^ {24'h0, byte_i};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    crc_o = c;
  end

endmodule

// File: hw/rtl/shcfr_parser.sv
// ----------------------------------------------------------------------------
// shcfr_parser
// Frame parse state: sync hunt, header capture, payload pass-through, CRC check.
// ----------------------------------------------------------------------------
module shcfr_parser
  import shcfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rxcrc_q, rxcrc_d;
  logic [7:0]  hdr_q [HdrLen];
  logic [7:0]  hdr_d [HdrLen];

  logic [31:0] crc_next;
  logic [15:0] cnt_inc;
  logic [15:0] len_hdr;
  logic [15:0] len_q;
  logic [31:0] rx_next;

  shcfr_crc8 u_crc8 (
    .crc_i  (crc_q),
    .byte_i (byte_i),
    .crc_o  (crc_next)
  );

  assign cnt_inc = cnt_q + 16'd1;
  assign len_hdr = {byte_i, hdr_q[4]};
  assign len_q   = {hdr_q[5], hdr_q[4]};
  assign rx_next = {byte_i, rxcrc_q[31:8]};

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    rxcrc_d     = rxcrc_q;
    hdr_d       = hdr_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (phase_q)
      PH_SYNC1: begin
        if (byte_i == cfg_i.sync_first) phase_d = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (byte_i == cfg_i.sync_second) begin
          phase_d = PH_HEADER;
          cnt_d   = '0;
          crc_d   = CrcInit;
          rxcrc_d = '0;
        end else if (byte_i != cfg_i.sync_first) begin
          phase_d = PH_SYNC1;
        end
      end
      PH_HEADER: begin
        if (cnt_q < 16'(HdrLen)) hdr_d[cnt_q[2:0]] = byte_i;
        crc_d = crc_next;
        cnt_d = cnt_inc;
        if (cnt_inc >= 16'(HdrLen)) begin
          cnt_d = '0;
          if (len_hdr > cfg_i.max_payload) begin
            // length out of range: report now and restart the hunt
            res_valid_o        = 1'b1;
            res_o.result_type  = ResVerdict;
            res_o.status       = StBadLength;
            res_o.command      = hdr_d[1];
            res_o.sequence_res = {hdr_d[3], hdr_d[2]};
            res_o.frame_length = len_hdr;
            res_o.computed_crc = ~crc_next;
            phase_d            = PH_SYNC1;
            crc_d              = CrcInit;
            rxcrc_d            = '0;
          end else begin
            phase_d = (len_hdr == 16'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_d = crc_next;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          cnt_d   = '0;
          phase_d = PH_CRC;
        end
        res_valid_o       = 1'b1;
        res_o.result_type = ResPayload;
        res_o.data_byte   = byte_i;
      end
      PH_CRC: begin
        rxcrc_d = rx_next;
        cnt_d   = cnt_inc;
        if (cnt_inc >= 16'(CrcLen)) begin
          res_valid_o        = 1'b1;
          res_o.result_type  = ResVerdict;
          res_o.command      = hdr_q[1];
          res_o.sequence_res = {hdr_q[3], hdr_q[2]};
          res_o.frame_length = len_q;
          res_o.computed_crc = ~crc_q;
          if (~crc_q != rx_next) begin
            res_o.status = StBadCrc;
          end else if (hdr_q[0] != cfg_i.expected_version) begin
            res_o.status = StBadVersion;
          end else begin
            res_o.status = StOk;
          end
          phase_d = PH_SYNC1;
          cnt_d   = '0;
          crc_d   = CrcInit;
          rxcrc_d = '0;
        end
      end
      default: begin
        phase_d = PH_SYNC1;
        cnt_d   = '0;
        crc_d   = CrcInit;
        rxcrc_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      cnt_q   <= '0;
      crc_q   <= CrcInit;
      rxcrc_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      rxcrc_q <= rxcrc_d;
    end
  end

  // header bytes carry no reset; each is written before it is read
  always_ff @(posedge clk_i) begin
    if (fire_i) hdr_q <= hdr_d;
  end

endmodule

// File: hw/rtl/sync_header_crc32_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// sync_header_crc32_frame_receiver_top
// Byte-serial frame receiver with sync hunt, header capture and CRC-32 check.
// ----------------------------------------------------------------------------
// Takes one received byte per word and sustains one byte per clock while the
// sink accepts result words. Each byte passes an input register, combinational
// parse and byte-wide CRC-32 logic, and a result register; a result word held
// by the sink holds the input register and stalls the byte stream for as long.
// Bytes during sync hunt, header and CRC trailer give no word; payload bytes
// come out as they arrive and each frame ends in one verdict word (ok, bad
// version, bad length after the header, or bad CRC). Configuration writes are
// applied at once and should only be made while no frame is in progress.
module sync_header_crc32_frame_receiver_top
  import shcfr_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  shcfr_rx_if.sink       rx_i,
  shcfr_res_if.source    res_o
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  res_t       out_q;
  logic       advance;
  logic       fire;
  logic       res_valid;
  res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first       <= SyncFirstRst;
      cfg_q.sync_second      <= SyncSecondRst;
      cfg_q.expected_version <= VersionRst;
      cfg_q.max_payload      <= MaxPayloadRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSyncFirst:  cfg_q.sync_first       <= cfg_wdata_i[7:0];
        RegSyncSecond: cfg_q.sync_second      <= cfg_wdata_i[7:0];
        RegVersion:    cfg_q.expected_version <= cfg_wdata_i[7:0];
        RegMaxPayload: cfg_q.max_payload      <= cfg_wdata_i;
        default:       cfg_q.max_payload      <= cfg_wdata_i;
      endcase
    end
  end

  // the input stage moves on whenever the result slot is free or being drained
  assign advance    = !out_valid_q || res_o.ready;
  assign fire       = in_valid_q && advance;
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) in_byte_q <= rx_i.rx_byte;
  end

  shcfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) out_q <= res;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.result_type  = out_q.result_type;
  assign res_o.data_byte    = out_q.data_byte;
  assign res_o.status       = out_q.status;
  assign res_o.command      = out_q.command;
  assign res_o.sequence_res = out_q.sequence_res;
  assign res_o.frame_length = out_q.frame_length;
  assign res_o.computed_crc = out_q.computed_crc;

endmodule
